>>> sv/tspc_pkg.sv
// Types, format classes and format decode shared by the pitch calculator.
package tspc_pkg;

	// Input beat: surface dimensions and format code
	typedef struct packed {
		logic [14:0] surf_width;
		logic [14:0] surf_height;
		logic [7:0]  pixel_format;
	} tspc_in_t;

	// Result beat: pitch, rows and total size
	typedef struct packed {
		logic [18:0] row_pitch;
		logic [15:0] row_count;
		logic [32:0] total_bytes;
	} tspc_out_t;

	// Format class, selects how rows and total are formed
	typedef enum logic [2:0] {
		CLS_LINEAR,
		CLS_BLOCK,
		CLS_PAIR,
		CLS_QUAD411,
		CLS_PLANE420
	} fmt_cls_t;

	// Bytes per unit of the row base; SC_BIT rounds bits up to bytes
	typedef enum logic [2:0] {
		SC_ZERO,
		SC_BIT,
		SC_X1,
		SC_X2,
		SC_X4,
		SC_X8,
		SC_X12,
		SC_X16
	} fmt_scale_t;

	typedef struct packed {
		fmt_cls_t   cls;
		fmt_scale_t scale;
	} fmt_info_t;

	// Work item handed from the front to the back
	typedef struct packed {
		fmt_cls_t    cls;
		logic [18:0] pitch;
		logic [15:0] rows;
		logic [14:0] mul_rows;
	} tspc_cmd_t;

	// Decode a format code into its class and byte scale
	function automatic fmt_info_t fmt_decode(input logic [7:0] f);
		fmt_info_t r;
		r.cls   = CLS_LINEAR;
		r.scale = SC_ZERO;
		case (f) inside
			[8'd70:8'd72], [8'd79:8'd81]: begin
				r.cls = CLS_BLOCK; r.scale = SC_X8;
			end
			[8'd73:8'd78], [8'd82:8'd84], [8'd94:8'd99]: begin
				r.cls = CLS_BLOCK; r.scale = SC_X16;
			end
			8'd68, 8'd69, 8'd107: begin
				r.cls = CLS_PAIR; r.scale = SC_X4;
			end
			8'd108, 8'd109: begin
				r.cls = CLS_PAIR; r.scale = SC_X8;
			end
			8'd110: begin
				r.cls = CLS_QUAD411; r.scale = SC_X4;
			end
			8'd103, 8'd106: begin
				r.cls = CLS_PLANE420; r.scale = SC_X2;
			end
			8'd104, 8'd105: begin
				r.cls = CLS_PLANE420; r.scale = SC_X4;
			end
			[8'd1:8'd4]:                   r.scale = SC_X16;
			[8'd5:8'd8]:                   r.scale = SC_X12;
			[8'd9:8'd22], 8'd102:          r.scale = SC_X8;
			[8'd23:8'd47], 8'd67:          r.scale = SC_X4;
			[8'd87:8'd93], [8'd100:8'd101]: r.scale = SC_X4;
			[8'd48:8'd59], [8'd85:8'd86]:  r.scale = SC_X2;
			[8'd114:8'd115]:               r.scale = SC_X2;
			[8'd60:8'd65], [8'd111:8'd113]: r.scale = SC_X1;
			8'd66:                         r.scale = SC_BIT;
			default:                       r.scale = SC_ZERO;
		endcase
		return r;
	endfunction

endpackage

>>> sv/tspc_front.sv
// Front end: accepts input beats, decodes the format and forms pitch and rows.
module tspc_front import tspc_pkg::*; #(
	parameter int unsigned MAX_DIM = 16384
) (
	input  logic      push,
	output logic      full,
	input  tspc_in_t  item,
	output logic      q_wr,
	input  logic      q_full,
	output tspc_cmd_t q_cmd
);

	localparam logic [16:0] DimMax = 17'(MAX_DIM);

	logic [16:0] w_ext, h_ext;
	logic [14:0] w, h;
	logic [15:0] w_p1, w_p3, w_p7, h_p1, h_p3;
	logic [14:0] base;
	logic [18:0] b19;
	logic [18:0] pitch;
	fmt_info_t   info;

	// Accept whenever the queue has room
	assign full = q_full;
	assign q_wr = push && !q_full;

	// Saturate dimensions to MAX_DIM; only the low 15 bits are kept
	assign w_ext = (17'(item.surf_width) > DimMax) ? DimMax : 17'(item.surf_width);
	assign h_ext = (17'(item.surf_height) > DimMax) ? DimMax : 17'(item.surf_height);
	assign w = w_ext[14:0];
	assign h = h_ext[14:0];

	assign info = fmt_decode(item.pixel_format);

	assign w_p1 = 16'(w) + 16'd1;
	assign w_p3 = 16'(w) + 16'd3;
	assign w_p7 = 16'(w) + 16'd7;
	assign h_p1 = 16'(h) + 16'd1;
	assign h_p3 = 16'(h) + 16'd3;

	// Select the row base for the class
	always_comb begin
		case (info.cls)
			CLS_BLOCK, CLS_QUAD411: base = 15'(w_p3[15:2]);
			CLS_PAIR, CLS_PLANE420: base = w_p1[15:1];
			default: begin
				if (info.scale == SC_BIT) begin
					base = 15'(w_p7[15:3]);
				end else begin
					base = w;
				end
			end
		endcase
	end

	assign b19 = 19'(base);

	// Scale the base to bytes
	always_comb begin
		case (info.scale)
			SC_BIT, SC_X1: pitch = b19;
			SC_X2:         pitch = b19 << 1;
			SC_X4:         pitch = b19 << 2;
			SC_X8:         pitch = b19 << 3;
			SC_X12:        pitch = (b19 << 3) + (b19 << 2);
			SC_X16:        pitch = b19 << 4;
			default:       pitch = '0;
		endcase
	end

	// Form row count and multiplier operand
	always_comb begin
		q_cmd.cls      = info.cls;
		q_cmd.pitch    = pitch;
		q_cmd.mul_rows = h;
		case (info.cls)
			CLS_BLOCK: begin
				q_cmd.rows     = 16'(h_p3[15:2]);
				q_cmd.mul_rows = 15'(h_p3[15:2]);
			end
			CLS_QUAD411:  q_cmd.rows = {h, 1'b0};
			CLS_PLANE420: q_cmd.rows = 16'(h) + 16'(h_p1[15:1]);
			CLS_PAIR:     q_cmd.rows = 16'(h);
			default: begin
				if (info.scale == SC_ZERO) begin
					q_cmd.rows = '0;
				end else begin
					q_cmd.rows = 16'(h);
				end
			end
		endcase
	end

endmodule

>>> sv/tspc_queue.sv
// Small FIFO between the front and back ends.
module tspc_queue import tspc_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  tspc_cmd_t wr_cmd,
	output logic      q_full,
	input  logic      rd,
	output tspc_cmd_t rd_cmd,
	output logic      q_valid
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

	tspc_cmd_t     mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign q_full  = (cnt_q == DepthCnt);
	assign q_valid = (cnt_q != '0);
	assign rd_cmd  = mem_q[rd_ptr_q];

	// Store incoming beats
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/tspc_back.sv
// Back end: multiplies pitch by rows and finishes the total per class.
module tspc_back import tspc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  tspc_cmd_t q_cmd,
	output logic      rd,
	output logic      empty,
	input  logic      pop,
	output tspc_out_t result
);

	logic        v_s1, v_s2;
	logic        adv_s1, adv_s2;
	fmt_cls_t    cls_s1;
	logic [18:0] pitch_s1;
	logic [15:0] rows_s1;
	logic [33:0] prod_s1;
	logic [34:0] prod_ext;
	logic [34:0] total;
	tspc_out_t   res_s2;

	// Each stage advances when the next one has room
	assign adv_s2 = !v_s2 || pop;
	assign adv_s1 = !v_s1 || adv_s2;
	assign rd     = q_valid && adv_s1;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= q_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (adv_s1 && q_valid) begin
			cls_s1   <= q_cmd.cls;
			pitch_s1 <= q_cmd.pitch;
			rows_s1  <= q_cmd.rows;
			prod_s1  <= 34'(q_cmd.pitch) * 34'(q_cmd.mul_rows);
		end
	end

	// Finish total: double for 4:1:1, add half chroma for 4:2:0
	assign prod_ext = 35'(prod_s1);
	always_comb begin
		case (cls_s1)
			CLS_QUAD411:  total = prod_ext << 1;
			CLS_PLANE420: total = prod_ext + ((prod_ext + 35'd1) >> 1);
			default:      total = prod_ext;
		endcase
	end

	// Output stage
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2.row_pitch   <= pitch_s1;
			res_s2.row_count   <= rows_s1;
			res_s2.total_bytes <= total[32:0];
		end
	end

	assign empty  = !v_s2;
	assign result = res_s2;

endmodule

>>> sv/texture_surface_pitch_calc.sv
// Top level of the texture surface pitch and size calculator.
//
//  port group           | dir | handshake         | beat
//  ---------------------+-----+-------------------+------------------------------------
//  push/full/item       | in  | push && !full     | surf_width, surf_height, pixel_format
//  empty/pop/result     | out | pop && !empty     | row_pitch, row_count, total_bytes
//
// One beat per cycle is accepted and one result per cycle delivered while pop
// is held. A beat passes through the front queue, then the multiply stage and
// the output stage of the back. Reset clears the queue and stage valids; no
// clearing pass is needed. When pop stays low the back stalls, and full rises
// once the two back stages and all QUEUE_DEPTH queue entries hold beats.
module texture_surface_pitch_calc import tspc_pkg::*; #(
	parameter int unsigned MAX_DIM     = 16384,
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  tspc_in_t  item,
	output logic      empty,
	input  logic      pop,
	output tspc_out_t result
);

	logic      q_wr, q_full, q_rd, q_valid;
	tspc_cmd_t wr_cmd, rd_cmd;

	tspc_front #(.MAX_DIM(MAX_DIM)) u_front (
		.push   (push),
		.full   (full),
		.item   (item),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_cmd  (wr_cmd)
	);

	tspc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_cmd  (wr_cmd),
		.q_full  (q_full),
		.rd      (q_rd),
		.rd_cmd  (rd_cmd),
		.q_valid (q_valid)
	);

	tspc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (rd_cmd),
		.rd      (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
